// ===== src/afe_pkg.sv =====
// Package for the API frame encoder: queue entry type, sequencer phases,
// line-protocol byte constants and the reserved-byte check.
// No dependencies.
package afe_pkg;

    localparam logic [7:0] DELIM_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] XON_BYTE   = 8'h11;
    localparam logic [7:0] XOFF_BYTE  = 8'h13;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] CHK_BASE   = 8'hFF;

    // One accepted body byte, classified, as it waits for the line sequencer
    typedef struct packed {
        logic [7:0]  body_byte;
        logic [15:0] body_length;
        logic        first_of_frame;
        logic        last_of_frame;
        logic [7:0]  checksum;
    } afe_entry_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_DELIM,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_CHK
    } afe_phase_t;

    function automatic logic is_reserved(input logic [7:0] b);
        logic r;
        case (b) inside
            DELIM_BYTE, ESC_BYTE, XON_BYTE, XOFF_BYTE: r = 1'b1;
            default:                                   r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/afe_front.sv =====
// Front end of the API frame encoder: accepts body bytes, keeps the running
// body sum and builds queue entries with the checksum. Uses afe_pkg.
module afe_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          body_byte,
    input  logic [15:0]         body_length,
    input  logic                first_of_frame,
    input  logic                last_of_frame,
    output logic                push_valid,
    input  logic                push_ready,
    output afe_pkg::afe_entry_t push_entry
);
    import afe_pkg::*;

    logic [7:0] body_sum_reg;
    logic [7:0] body_sum_next;
    logic [7:0] sum_new;
    logic       accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb begin
        sum_new = first_of_frame ? body_byte : body_sum_reg + body_byte;
        body_sum_next = body_sum_reg;
        if (accept) begin
            body_sum_next = last_of_frame ? 8'h00 : sum_new;
        end
    end

    always_comb begin
        push_entry.body_byte      = body_byte;
        push_entry.body_length    = body_length;
        push_entry.first_of_frame = first_of_frame;
        push_entry.last_of_frame  = last_of_frame;
        push_entry.checksum       = CHK_BASE - sum_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_sum_reg <= 8'h00;
        end else begin
            body_sum_reg <= body_sum_next;
        end
    end

endmodule

// ===== src/afe_queue.sv =====
// Short entry queue between front and back of the API frame encoder.
// Uses afe_pkg for the entry type.
module afe_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  afe_pkg::afe_entry_t in_entry,
    output logic                out_valid,
    input  logic                out_pop,
    output afe_pkg::afe_entry_t out_entry
);
    import afe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    afe_entry_t       slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = slots[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

// ===== src/afe_back.sv =====
// Back end of the API frame encoder: walks each queued entry through the
// delimiter, length, body and checksum phases it needs, escaping reserved bytes
// in escape_mode, and drives the registered output stream. Uses afe_pkg.
module afe_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                escape_mode,
    input  logic                head_valid,
    input  afe_pkg::afe_entry_t head_entry,
    output logic                head_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          line_byte,
    output logic                run_end,
    output logic                frame_end
);
    import afe_pkg::*;

    afe_phase_t phase_reg, phase_next;
    afe_phase_t cur_phase, phase_after;
    logic       esc_second_reg, esc_second_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] line_byte_reg;
    logic       run_end_reg, frame_end_reg;

    logic [7:0] raw_byte;
    logic [7:0] emit_byte;
    logic       needs_esc;
    logic       byte_done;
    logic       item_done;
    logic       load;

    assign load = head_valid && (!out_valid_reg || out_ready);

    // Resolve the start of an entry to its first real phase
    assign cur_phase = (phase_reg == PH_START) ?
                       (head_entry.first_of_frame ? PH_DELIM : PH_BODY) : phase_reg;

    // Next-phase logic
    always_comb begin
        unique case (cur_phase)
            PH_DELIM:  phase_after = PH_LEN_HI;
            PH_LEN_HI: phase_after = PH_LEN_LO;
            PH_LEN_LO: phase_after = PH_BODY;
            PH_BODY:   phase_after = head_entry.last_of_frame ? PH_CHK : PH_START;
            default:   phase_after = PH_START;
        endcase
        phase_next      = phase_reg;
        esc_second_next = esc_second_reg;
        if (load) begin
            if (byte_done) begin
                phase_next      = phase_after;
                esc_second_next = 1'b0;
            end else begin
                phase_next      = cur_phase;
                esc_second_next = 1'b1;
            end
        end
    end

    // Output logic
    always_comb begin
        unique case (cur_phase)
            PH_DELIM:  raw_byte = DELIM_BYTE;
            PH_LEN_HI: raw_byte = head_entry.body_length[15:8];
            PH_LEN_LO: raw_byte = head_entry.body_length[7:0];
            PH_BODY:   raw_byte = head_entry.body_byte;
            default:   raw_byte = head_entry.checksum;
        endcase
        needs_esc = escape_mode && (cur_phase != PH_DELIM) && is_reserved(raw_byte);
        if (esc_second_reg) begin
            emit_byte = raw_byte ^ ESC_XOR;
            byte_done = 1'b1;
        end else if (needs_esc) begin
            emit_byte = ESC_BYTE;
            byte_done = 1'b0;
        end else begin
            emit_byte = raw_byte;
            byte_done = 1'b1;
        end
        item_done = byte_done && (phase_after == PH_START);
        head_pop  = load && item_done;

        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            esc_second_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            esc_second_reg <= esc_second_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            line_byte_reg <= emit_byte;
            run_end_reg   <= item_done;
            frame_end_reg <= byte_done && (cur_phase == PH_CHK);
        end
    end

    assign out_valid = out_valid_reg;
    assign line_byte = line_byte_reg;
    assign run_end   = run_end_reg;
    assign frame_end = frame_end_reg;

endmodule

// ===== src/api_frame_escaped_encoder.sv =====
// Top level of the API frame encoder: config register, front end, entry
// queue and line sequencer. Uses afe_pkg, afe_front, afe_queue, afe_back.
//
//   channel  | direction | tdata / data               | tuser          | tlast
//   ---------+-----------+----------------------------+----------------+--------------
//   s_       | in        | body_byte, body_length     | first_of_frame | last_of_frame
//   m_       | out       | line_byte                  | run_end        | frame_end
//   cfg_     | in        | escape_mode                | -              | -
//
// The line sequencer emits one line byte per cycle as m_ and the queue allow;
// a body byte gives 1 byte, 2 when escaped; a first byte adds 3 to 5 of header,
// a last byte 1 or 2 of checksum. Input transfers are taken as they arrive
// while the queue (QUEUE_DEPTH entries) has room, so m_ stalls reach s_tready
// only once it fills. Reset clears body sum, queue, sequencer and escape_mode.
module api_frame_escaped_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] body_byte, [23:8] body_length
    input  logic        s_tuser,   // [0] first_of_frame
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] line_byte
    output logic        m_tuser,   // [0] run_end
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import afe_pkg::*;

    logic       escape_mode_reg, escape_mode_next;
    logic       push_valid, push_ready;
    afe_entry_t push_entry;
    logic       head_valid, head_pop;
    afe_entry_t head_entry;

    assign cfg_ready = 1'b1;

    always_comb begin
        escape_mode_next = escape_mode_reg;
        if (cfg_valid && cfg_ready) begin
            escape_mode_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_mode_reg <= 1'b0;
        end else begin
            escape_mode_reg <= escape_mode_next;
        end
    end

    afe_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .body_byte      (s_tdata[7:0]),
        .body_length    (s_tdata[23:8]),
        .first_of_frame (s_tuser),
        .last_of_frame  (s_tlast),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_entry     (push_entry)
    );

    afe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (head_valid),
        .out_pop   (head_pop),
        .out_entry (head_entry)
    );

    afe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .escape_mode (escape_mode_reg),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .head_pop    (head_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .line_byte   (m_tdata),
        .run_end     (m_tuser),
        .frame_end   (m_tlast)
    );

    // checksum byte always closes the run of its item
    a_frame_end_is_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("frame_end without run_end");

    // an accepted transfer is held somewhere until it reaches the output
    a_accept_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid || head_valid)
        else $error("accepted item vanished");

    // the queue only pops entries it holds
    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ===== test/tb_top.sv =====
// Testbench for api_frame_escaped_encoder: drives frame body bytes over the s_ stream,
// predicts the encoded line bytes with a scoreboard class and checks the m_ stream.
// Depends on afe_pkg and the encoder RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import afe_pkg::*;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_end;
        logic       frame_end;
    } line_entry_t;

    // Predicts the line bytes of each body byte and checks them in order
    class frame_line_scoreboard;
        logic        escape_mode;
        logic [7:0]  body_sum;
        line_entry_t expected_line[$];
        int          mismatches;
        int          body_bytes;
        int          line_bytes;
        int          frames_closed;

        function new();
            escape_mode   = 1'b0;
            body_sum      = 8'h00;
            mismatches    = 0;
            body_bytes    = 0;
            line_bytes    = 0;
            frames_closed = 0;
        endfunction

        function int pending();
            return expected_line.size();
        endfunction

        // Escaping applies to everything after the delimiter
        function void push_line(input logic [7:0] b, input logic stuffable);
            if (stuffable && escape_mode &&
                (b == DELIM_BYTE || b == ESC_BYTE || b == XON_BYTE || b == XOFF_BYTE)) begin
                expected_line.push_back('{ESC_BYTE, 1'b0, 1'b0});
                expected_line.push_back('{b ^ ESC_XOR, 1'b0, 1'b0});
            end else begin
                expected_line.push_back('{b, 1'b0, 1'b0});
            end
        endfunction

        function void note_body_byte(input logic [7:0] b, input logic [15:0] len,
                                     input logic first, input logic last);
            body_bytes++;
            if (first) begin
                push_line(DELIM_BYTE, 1'b0);
                push_line(len[15:8], 1'b1);
                push_line(len[7:0], 1'b1);
                body_sum = b;
            end else begin
                body_sum = body_sum + b;
            end
            push_line(b, 1'b1);
            if (last) begin
                push_line(CHK_BASE - body_sum, 1'b1);
                expected_line[expected_line.size() - 1].frame_end = 1'b1;
                body_sum = 8'h00;
            end
            expected_line[expected_line.size() - 1].run_end = 1'b1;
        endfunction

        function void check_line_byte(input logic [7:0] d, input logic run_end,
                                      input logic frame_end);
            line_entry_t exp;
            line_bytes++;
            if (frame_end === 1'b1)
                frames_closed++;
            if (expected_line.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected line byte %02h run_end=%b frame_end=%b",
                             d, run_end, frame_end);
                return;
            end
            exp = expected_line.pop_front();
            if (d !== exp.line_byte || run_end !== exp.run_end || frame_end !== exp.frame_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: line byte %0d: expected %02h/%b/%b, got %02h/%b/%b",
                             line_bytes, exp.line_byte, exp.run_end, exp.frame_end,
                             d, run_end, frame_end);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] body_byte, [23:8] body_length
    logic        s_tuser;   // [0] first_of_frame
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] line_byte
    logic        m_tuser;   // [0] run_end
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    frame_line_scoreboard sb = new();
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit hold_req     = 1'b0;

    api_frame_escaped_encoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d line bytes still expected", sb.pending());
        $display("Some tests failed");
        $finish;
    end

    // Line side: checks each transfer, stalls in random bursts, and once holds off
    // long enough for the entry queue to fill up
    initial begin : line_sink
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_line_byte(m_tdata, m_tuser, m_tlast);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_body(input logic [7:0] b, input logic [15:0] len,
                             input logic first, input logic last);
        int gap;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, b};
        s_tuser  <= first;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_body_byte(b, len, first, last);
    endtask

    // Register writes only once all line bytes are out and the block is quiet
    task automatic write_escape_mode(input logic mode);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.escape_mode = mode;
    endtask

    function automatic logic [7:0] pick_body_byte();
        case ($urandom_range(0, 7))
            0:       return DELIM_BYTE;
            1:       return ESC_BYTE;
            2:       return XON_BYTE;
            3:       return XOFF_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly whole frames with random content; some with a random length field,
    // some stray bytes with random marks
    task automatic send_random_traffic(input int n_items);
        int          n;
        int          i;
        int          sent;
        logic [15:0] len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                n   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
                len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(n);
                for (i = 0; i < n; i++)
                    send_body(pick_body_byte(), (i == 0) ? len : 16'($urandom),
                              i == 0, i == n - 1);
                sent += n;
            end else begin
                send_body(pick_body_byte(), 16'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // raw mode: zero length, extremes, stray bytes without a start
        write_escape_mode(1'b0);
        send_body(8'h00, 16'h0000, 1'b1, 1'b1);
        send_body(8'hFF, 16'hFFFF, 1'b1, 1'b0);
        send_body(DELIM_BYTE, 16'h0000, 1'b0, 1'b0);
        send_body(XON_BYTE, 16'h0000, 1'b0, 1'b1);
        send_body(8'h55, 16'h1234, 1'b0, 1'b0);
        send_body(8'hAA, 16'h0000, 1'b0, 1'b1);

        // escaped mode: reserved length bytes, body bytes and checksums
        write_escape_mode(1'b1);
        send_body(8'h81, 16'h7E7D, 1'b1, 1'b1);
        send_body(XOFF_BYTE, 16'h1113, 1'b1, 1'b1);
        send_body(8'h82, 16'h0001, 1'b1, 1'b1);
        send_body(8'hEE, 16'h8000, 1'b1, 1'b1);
        send_body(8'hEC, 16'h0100, 1'b1, 1'b1);
        send_body(8'hFF, 16'hFFFF, 1'b1, 1'b1);
        // repeated start drops the open frame without a checksum
        send_body(ESC_BYTE, 16'h0005, 1'b1, 1'b0);
        send_body(8'h20, 16'h0000, 1'b0, 1'b0);
        send_body(XON_BYTE, 16'h0002, 1'b1, 1'b0);
        send_body(DELIM_BYTE, 16'h0000, 1'b0, 1'b1);
        send_body(8'h00, 16'h0000, 1'b1, 1'b1);

        // back-to-back bytes while the line side holds off
        src_idle_on = 1'b0;
        hold_req    = 1'b1;
        send_random_traffic(12);
        src_idle_on = 1'b1;
        send_random_traffic(20);

        write_escape_mode(1'b0);
        send_random_traffic(25);

        write_escape_mode(1'b1);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_random_traffic(25);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        $display("Run covered %0d body bytes in both escape settings, %0d line bytes checked,",
                 sb.body_bytes, sb.line_bytes);
        $display("%0d frames closed with a checksum, %0d mismatches", sb.frames_closed,
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
